// File: src/dual_wheel_pi_speed_loop_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual-wheel PI speed loop
// Clock and reset are the block's own clock and reset ports.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PI_SPEED_LOOP_CORE_MACROS_SVH
`define DUAL_WHEEL_PI_SPEED_LOOP_CORE_MACROS_SVH

// check cond on every edge out of reset
`define DWPI_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// check cons in the same cycle as ante
`define DWPI_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define DWPI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/dwpi_pkg.sv
// ----------------------------------------------------------------------------
// dwpi_pkg
// Widths, constants and types shared by the dual-wheel PI speed loop.
// ----------------------------------------------------------------------------
`default_nettype none

package dwpi_pkg;

   localparam int unsigned PWM_TOP_DEF = 800;
   localparam int unsigned PWM_MID_DEF = 400;

   localparam int COUNT_W   = 32;
   localparam int TGT_W     = 21;
   localparam int DUTY_W    = 10;
   localparam int GAIN_W    = 18;
   localparam int DELTA_W   = 16;
   localparam int SPEED_W   = 21;
   localparam int SUM_W     = 23;
   localparam int ERR_W     = 30;
   localparam int HI_W      = ERR_W + 1;
   localparam int PROD_W    = HI_W + GAIN_W;
   localparam int INTEG_W   = 40;
   localparam int U_W       = 44;
   localparam int STEP_W    = 5;
   localparam int Q_SHIFT   = 16;
   localparam int FRAC_DROP = 8;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [DELTA_W-1:0] DELTA_LIM = 16'sd32767;
   localparam logic [GAIN_W-1:0] THIRD_Q16 = 18'd21843;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GAIN_W - 1);

   localparam logic [GAIN_W-1:0] PROP_LEFT_RST   = 18'd42318;
   localparam logic [GAIN_W-1:0] PROP_RIGHT_RST  = 18'd60667;
   localparam logic [GAIN_W-1:0] INTEG_LEFT_RST  = 18'd3385;
   localparam logic [GAIN_W-1:0] INTEG_RIGHT_RST = 18'd3026;

   typedef enum logic [1:0] {
      REG_PROP_LEFT,
      REG_PROP_RIGHT,
      REG_INTEG_LEFT,
      REG_INTEG_RIGHT
   } csr_index_type;

   typedef enum logic [3:0] {
      W_IDLE,
      W_DELTA,
      W_SUM,
      W_FILT,
      W_ERR,
      W_GAIN,
      W_INTEG,
      W_OUT,
      W_CLAMP
   } wheel_state_type;

   typedef enum logic {
      T_IDLE,
      T_BUSY
   } top_state_type;

   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
   } gain_type;

   typedef struct packed {
      logic start;
      logic drain;
   } lane_ctl_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] duty;
      logic              clamp;
   } lane_sts_type;

endpackage

`default_nettype wire

// File: src/dwpi_req_if.sv
// ----------------------------------------------------------------------------
// dwpi_req_if
// Input channel: encoder counts and speed setpoints for both wheels.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwpi_req_if import dwpi_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [COUNT_W-1:0] count_left;
   logic signed [COUNT_W-1:0] count_right;
   logic signed [TGT_W-1:0]   target_speed_left;
   logic signed [TGT_W-1:0]   target_speed_right;

   modport source (
      output valid, count_left, count_right, target_speed_left, target_speed_right,
      input  ready
   );

   modport sink (
      input  valid, count_left, count_right, target_speed_left, target_speed_right,
      output ready
   );
endinterface

`default_nettype wire

// File: src/dwpi_rsp_if.sv
// ----------------------------------------------------------------------------
// dwpi_rsp_if
// Result channel: PWM duty and clamp flag for both wheels.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwpi_rsp_if import dwpi_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_left;
   logic [DUTY_W-1:0] duty_right;
   logic              clamp_left;
   logic              clamp_right;

   modport source (
      output valid, duty_left, duty_right, clamp_left, clamp_right,
      input  ready
   );

   modport sink (
      input  valid, duty_left, duty_right, clamp_left, clamp_right,
      output ready
   );
endinterface

`default_nettype wire

// File: src/dual_wheel_pi_speed_loop_core.sv
// ----------------------------------------------------------------------------
// dual_wheel_pi_speed_loop_core
// A request word is accepted only while the core is idle, and the next word
// waits until the last one's duties are registered. Each wheel lane runs two
// 18-step bit-serial multiplies (speed filter, then P and I gains) per word.
// Reset clears counts, speed history and integrators and loads default gains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_wheel_pi_speed_loop_core_macros.svh"

module dual_wheel_pi_speed_loop_core import dwpi_pkg::*; #(
   parameter int unsigned PWM_TOP = PWM_TOP_DEF,
   parameter int unsigned PWM_MID = PWM_MID_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   dwpi_req_if.sink                   req_chan,
   dwpi_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam logic [DUTY_W-1:0] TOP_DUTY = DUTY_W'(PWM_TOP);

   top_state_type     state_ff, state_in;
   logic [GAIN_W-1:0] prop_l_ff, prop_r_ff, integ_l_ff, integ_r_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] duty_l_ff, duty_r_ff;
   logic              clamp_l_ff, clamp_r_ff;

   csr_index_type     csr_index;
   logic              csr_write;
   logic              accept;
   lane_ctl_type      ctl;
   gain_type          gain_l, gain_r;
   lane_sts_type      sts_l, sts_r;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_l_ff  <= PROP_LEFT_RST;
         prop_r_ff  <= PROP_RIGHT_RST;
         integ_l_ff <= INTEG_LEFT_RST;
         integ_r_ff <= INTEG_RIGHT_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_PROP_LEFT:   prop_l_ff  <= csr_pwdata[GAIN_W-1:0];
            REG_PROP_RIGHT:  prop_r_ff  <= csr_pwdata[GAIN_W-1:0];
            REG_INTEG_LEFT:  integ_l_ff <= csr_pwdata[GAIN_W-1:0];
            REG_INTEG_RIGHT: integ_r_ff <= csr_pwdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PROP_LEFT:   csr_prdata = CSR_DATA_W'(prop_l_ff);
         REG_PROP_RIGHT:  csr_prdata = CSR_DATA_W'(prop_r_ff);
         REG_INTEG_LEFT:  csr_prdata = CSR_DATA_W'(integ_l_ff);
         REG_INTEG_RIGHT: csr_prdata = CSR_DATA_W'(integ_r_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign gain_l = '{prop: prop_l_ff, integ: integ_l_ff};
   assign gain_r = '{prop: prop_r_ff, integ: integ_r_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      req_chan.ready = 1'b0;
      accept         = 1'b0;
      ctl.start      = 1'b0;
      ctl.drain      = !rsp_valid_ff || rsp_chan.ready;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         T_IDLE: begin
            req_chan.ready = 1'b1;
            accept         = req_chan.valid;
            ctl.start      = accept;
            if (accept) begin
               state_in = T_BUSY;
            end
         end
         T_BUSY: begin
            if (sts_l.done) begin
               rsp_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (sts_l.done) begin
         duty_l_ff  <= sts_l.duty;
         clamp_l_ff <= sts_l.clamp;
         duty_r_ff  <= sts_r.duty;
         clamp_r_ff <= sts_r.clamp;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.duty_left   = duty_l_ff;
   assign rsp_chan.duty_right  = duty_r_ff;
   assign rsp_chan.clamp_left  = clamp_l_ff;
   assign rsp_chan.clamp_right = clamp_r_ff;

   dwpi_wheel #(
      .PWM_TOP (PWM_TOP),
      .PWM_MID (PWM_MID)
   ) u_wheel_left (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .gain   (gain_l),
      .count  (req_chan.count_left),
      .target (req_chan.target_speed_left),
      .sts    (sts_l)
   );

   dwpi_wheel #(
      .PWM_TOP (PWM_TOP),
      .PWM_MID (PWM_MID)
   ) u_wheel_right (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .gain   (gain_r),
      .count  (req_chan.count_right),
      .target (req_chan.target_speed_right),
      .sts    (sts_r)
   );

   `DWPI_ASSERT_ALWAYS(a_lanes_lockstep, sts_l.done == sts_r.done, "wheel lanes out of step")
   `DWPI_ASSERT_IMPLY(a_done_busy, sts_l.done, state_ff == T_BUSY, "lane done while idle")
   `DWPI_ASSERT_IMPLY(a_slot_free, sts_l.done, !rsp_valid_ff || rsp_chan.ready, "response overrun")
   `DWPI_ASSERT_NEXT(a_accept_blocks, accept, !req_chan.ready, "second word taken while busy")
   `DWPI_ASSERT_IMPLY(a_clamp_duty, rsp_valid_ff && clamp_l_ff,
      duty_l_ff == '0 || duty_l_ff == TOP_DUTY, "left clamp with mid-range duty")

endmodule

`default_nettype wire

// File: src/dwpi_wheel.sv
// ----------------------------------------------------------------------------
// dwpi_wheel
// One wheel's speed loop: count delta, 3-tap average, error, and PI term
// with anti-windup. Products come from two shift-add units, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpi_wheel import dwpi_pkg::*; #(
   parameter int unsigned PWM_TOP = PWM_TOP_DEF,
   parameter int unsigned PWM_MID = PWM_MID_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lane_ctl_type              ctl,
   input  wire gain_type                  gain,
   input  wire logic signed [COUNT_W-1:0] count,
   input  wire logic signed [TGT_W-1:0]   target,
   output lane_sts_type                   sts
);

   localparam logic signed [U_W-1:0] MID_Q = U_W'(PWM_MID) <<< Q_SHIFT;
   localparam logic signed [U_W-1:0] TOP_Q = U_W'(PWM_TOP) <<< Q_SHIFT;
   localparam logic [DUTY_W-1:0] TOP_DUTY = DUTY_W'(PWM_TOP);
   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   wheel_state_type           state_ff, state_in;
   logic signed [COUNT_W-1:0] cnt_ff, cnt_in;
   logic signed [COUNT_W-1:0] prev_ff, prev_in;
   logic signed [TGT_W-1:0]   tgt_ff, tgt_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic signed [SPEED_W-1:0] hist0_ff, hist0_in;
   logic signed [SPEED_W-1:0] hist1_ff, hist1_in;
   logic signed [ERR_W-1:0]   mcand_ff, mcand_in;
   logic signed [HI_W-1:0]    hi_a_ff, hi_a_in;
   logic signed [HI_W-1:0]    hi_b_ff, hi_b_in;
   logic [GAIN_W-1:0]         lo_a_ff, lo_a_in;
   logic [GAIN_W-1:0]         lo_b_ff, lo_b_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [INTEG_W-1:0] next_ff, next_in;
   logic signed [INTEG_W-1:0] p_ff, p_in;
   logic signed [U_W-1:0]     u_ff, u_in;

   logic signed [COUNT_W-1:0] diff;
   logic signed [DELTA_W-1:0] delta;
   logic signed [SPEED_W-1:0] d_ext;
   logic signed [SPEED_W-1:0] speed;
   logic signed [SUM_W-1:0]   sum3;
   logic signed [HI_W-1:0]    add_a, add_b;
   logic signed [HI_W-1:0]    hi_a_step, hi_b_step;
   logic [GAIN_W-1:0]         lo_a_step, lo_b_step;
   logic signed [PROD_W-1:0]  prod_a, prod_b;
   logic signed [ERR_W-1:0]   filt;
   logic signed [ERR_W-1:0]   err;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_sat;
   logic signed [INTEG_W:0]   ctrl_sum;
   logic signed [U_W-1:0]     u;
   logic                      clamp_hi, clamp_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         prev_ff  <= '0;
         hist0_ff <= '0;
         hist1_ff <= '0;
         integ_ff <= '0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
         hist0_ff <= hist0_in;
         hist1_ff <= hist1_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      tgt_ff   <= tgt_in;
      speed_ff <= speed_in;
      mcand_ff <= mcand_in;
      hi_a_ff  <= hi_a_in;
      hi_b_ff  <= hi_b_in;
      lo_a_ff  <= lo_a_in;
      lo_b_ff  <= lo_b_in;
      step_ff  <= step_in;
      next_ff  <= next_in;
      p_ff     <= p_in;
      u_ff     <= u_in;
   end

   always_comb begin
      diff = cnt_ff - prev_ff;
      if (diff > COUNT_W'(DELTA_LIM)) begin
         delta = DELTA_LIM;
      end else if (diff < -COUNT_W'(DELTA_LIM)) begin
         delta = -DELTA_LIM;
      end else begin
         delta = diff[DELTA_W-1:0];
      end
      d_ext = SPEED_W'(delta);
      speed = (d_ext <<< 4) + (d_ext <<< 3) + d_ext;
      sum3  = SUM_W'(hist0_ff) + SUM_W'(hist1_ff) + SUM_W'(speed_ff);

      add_a     = hi_a_ff + (lo_a_ff[0] ? HI_W'(mcand_ff) : '0);
      add_b     = hi_b_ff + (lo_b_ff[0] ? HI_W'(mcand_ff) : '0);
      hi_a_step = {add_a[HI_W-1], add_a[HI_W-1:1]};
      hi_b_step = {add_b[HI_W-1], add_b[HI_W-1:1]};
      lo_a_step = {add_a[0], lo_a_ff[GAIN_W-1:1]};
      lo_b_step = {add_b[0], lo_b_ff[GAIN_W-1:1]};
      prod_a    = {hi_a_ff, lo_a_ff};
      prod_b    = {hi_b_ff, lo_b_ff};

      filt = prod_a[ERR_W+FRAC_DROP-1:FRAC_DROP];
      err  = ERR_W'(tgt_ff) - filt;

      integ_sum = (INTEG_W+1)'(integ_ff)
                + (INTEG_W+1)'($signed(prod_a[INTEG_W+FRAC_DROP-1:FRAC_DROP]));
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end

      ctrl_sum = (INTEG_W+1)'(p_ff) + (INTEG_W+1)'(next_ff);
      u        = MID_Q - U_W'(ctrl_sum);
      clamp_hi = u_ff > TOP_Q;
      clamp_lo = u_ff[U_W-1];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      prev_in  = prev_ff;
      tgt_in   = tgt_ff;
      speed_in = speed_ff;
      hist0_in = hist0_ff;
      hist1_in = hist1_ff;
      mcand_in = mcand_ff;
      hi_a_in  = hi_a_ff;
      hi_b_in  = hi_b_ff;
      lo_a_in  = lo_a_ff;
      lo_b_in  = lo_b_ff;
      step_in  = step_ff;
      integ_in = integ_ff;
      next_in  = next_ff;
      p_in     = p_ff;
      u_in     = u_ff;

      sts.done  = 1'b0;
      sts.clamp = clamp_hi | clamp_lo;
      if (clamp_hi) begin
         sts.duty = TOP_DUTY;
      end else if (clamp_lo) begin
         sts.duty = '0;
      end else begin
         sts.duty = u_ff[Q_SHIFT +: DUTY_W];
      end

      case (state_ff)
         W_IDLE: begin
            if (ctl.start) begin
               cnt_in   = count;
               tgt_in   = target;
               state_in = W_DELTA;
            end
         end
         W_DELTA: begin
            speed_in = speed;
            prev_in  = cnt_ff;
            state_in = W_SUM;
         end
         W_SUM: begin
            mcand_in = ERR_W'(sum3);
            hist0_in = hist1_ff;
            hist1_in = speed_ff;
            hi_a_in  = '0;
            lo_a_in  = THIRD_Q16;
            hi_b_in  = '0;
            lo_b_in  = '0;
            step_in  = '0;
            state_in = W_FILT;
         end
         W_FILT: begin
            hi_a_in = hi_a_step;
            lo_a_in = lo_a_step;
            hi_b_in = hi_b_step;
            lo_b_in = lo_b_step;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = W_ERR;
            end
         end
         W_ERR: begin
            mcand_in = err;
            hi_a_in  = '0;
            lo_a_in  = gain.integ;
            hi_b_in  = '0;
            lo_b_in  = gain.prop;
            step_in  = '0;
            state_in = W_GAIN;
         end
         W_GAIN: begin
            hi_a_in = hi_a_step;
            lo_a_in = lo_a_step;
            hi_b_in = hi_b_step;
            lo_b_in = lo_b_step;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = W_INTEG;
            end
         end
         W_INTEG: begin
            next_in  = integ_sat;
            p_in     = prod_b[INTEG_W+FRAC_DROP-1:FRAC_DROP];
            state_in = W_OUT;
         end
         W_OUT: begin
            u_in     = u;
            state_in = W_CLAMP;
         end
         W_CLAMP: begin
            if (ctl.drain) begin
               sts.done = 1'b1;
               if (!(clamp_hi || clamp_lo)) begin
                  integ_in = next_ff;
               end
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Control-tick testbench for dual_wheel_pi_speed_loop_core.
// Reads back the gain registers and drives directed ticks: encoder wrap,
// saturating count jumps and clamping at both duty limits.
// Checks extreme gain settings, then random gains with wheel tracks that
// cruise, slip and jump, under random idling on the request and response
// sides. An in-bench model of the filter, PI and anti-windup predicts each
// duty word, and every response is compared field by field.
// ----------------------------------------------------------------------------

module tb;
   import dwpi_pkg::*;

   localparam longint ONE_THIRD  = 21843;
   localparam longint SPEED_MUL  = 25;
   localparam longint DELTA_CLIP = 32767;
   localparam longint PWM_MID_L  = PWM_MID_DEF;
   localparam longint PWM_TOP_L  = PWM_TOP_DEF;
   localparam longint MID_Q16    = PWM_MID_L <<< Q_SHIFT;
   localparam longint TOP_Q16    = PWM_TOP_L <<< Q_SHIFT;
   localparam longint INTEG_HI   = (64'sd1 <<< (INTEG_W - 1)) - 1;
   localparam longint INTEG_LO   = -INTEG_HI - 1;
   localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
   localparam int SPEED_PER_COUNT = 6400;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_left;
      logic [DUTY_W-1:0] duty_right;
      logic              clamp_left;
      logic              clamp_right;
   } duty_word_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dwpi_req_if req_chan ();
   dwpi_rsp_if rsp_chan ();

   dual_wheel_pi_speed_loop_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // loop model state, index 0 is the left wheel
   logic [GAIN_W-1:0]         prop_gain [2];
   logic [GAIN_W-1:0]         integ_gain [2];
   logic [COUNT_W-1:0]        last_count [2];
   logic signed [SPEED_W-1:0] speed_hist [2][2];
   logic signed [INTEG_W-1:0] integrator [2];

   duty_word_type duty_expected [$];

   int errors        = 0;
   int ticks_sent    = 0;
   int words_checked = 0;
   int clamps_seen   = 0;
   int gain_writes   = 0;
   int ready_hold    = 0;
   bit steady_flow   = 1'b0;

   logic [COUNT_W-1:0] enc_pos [2];
   int                 cruise [2];

   function automatic void step_wheel(input int w, input logic [COUNT_W-1:0] cnt,
                                      input logic signed [TGT_W-1:0] tgt,
                                      output logic [DUTY_W-1:0] duty, output logic clamp);
      logic signed [COUNT_W-1:0] diff;
      longint delta, speed, sum, filt, err, kp, ki, p, inc, nxt, u;
      diff = cnt - last_count[w];
      last_count[w] = cnt;
      delta = diff;
      if (delta > DELTA_CLIP) delta = DELTA_CLIP;
      if (delta < -DELTA_CLIP) delta = -DELTA_CLIP;
      speed = delta * SPEED_MUL;
      sum = speed_hist[w][0] + speed_hist[w][1] + speed;
      speed_hist[w][0] = speed_hist[w][1];
      speed_hist[w][1] = speed[SPEED_W-1:0];
      filt = (sum * ONE_THIRD) >>> FRAC_DROP;
      err = tgt - filt;
      kp = prop_gain[w];
      ki = integ_gain[w];
      p = (kp * err) >>> FRAC_DROP;
      inc = (ki * err) >>> FRAC_DROP;
      nxt = integrator[w] + inc;
      if (nxt > INTEG_HI) nxt = INTEG_HI;
      if (nxt < INTEG_LO) nxt = INTEG_LO;
      u = MID_Q16 - (p + nxt);
      if (u > TOP_Q16) begin
         duty = DUTY_W'(PWM_TOP_DEF);
         clamp = 1'b1;
      end else if (u < 0) begin
         duty = '0;
         clamp = 1'b1;
      end else begin
         duty = DUTY_W'(u >>> Q_SHIFT);
         clamp = 1'b0;
         integrator[w] = nxt[INTEG_W-1:0];
      end
   endfunction

   function automatic void predict_tick(input logic [COUNT_W-1:0] cl, cr,
                                        input logic [TGT_W-1:0] tl, tr);
      duty_word_type want;
      step_wheel(0, cl, tl, want.duty_left, want.clamp_left);
      step_wheel(1, cr, tr, want.duty_right, want.clamp_right);
      clamps_seen += want.clamp_left + want.clamp_right;
      duty_expected.push_back(want);
   endfunction

   function automatic logic [GAIN_W-1:0] gain_of(input csr_index_type idx);
      case (idx)
         REG_PROP_LEFT:  return prop_gain[0];
         REG_PROP_RIGHT: return prop_gain[1];
         REG_INTEG_LEFT: return integ_gain[0];
         default:        return integ_gain[1];
      endcase
   endfunction

   function automatic int idle_len();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   function automatic void check_field(input string name, input logic [DUTY_W-1:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      int stall;
      duty_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         ready_hold <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (duty_expected.size() == 0) begin
               $error("unexpected duty word: left %0d, right %0d",
                      rsp_chan.duty_left, rsp_chan.duty_right);
               errors++;
            end else begin
               want = duty_expected.pop_front();
               check_field("duty_left", want.duty_left, rsp_chan.duty_left);
               check_field("duty_right", want.duty_right, rsp_chan.duty_right);
               check_field("clamp_left", DUTY_W'(want.clamp_left), DUTY_W'(rsp_chan.clamp_left));
               check_field("clamp_right", DUTY_W'(want.clamp_right),
                           DUTY_W'(rsp_chan.clamp_right));
               words_checked++;
            end
         end
         if (ready_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            ready_hold <= ready_hold - 1;
         end else begin
            stall = idle_len();
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               ready_hold <= stall - 1;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_word(input logic [COUNT_W-1:0] cl, cr, input logic [TGT_W-1:0] tl, tr);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.count_left         <= cl;
      req_chan.count_right        <= cr;
      req_chan.target_speed_left  <= tl;
      req_chan.target_speed_right <= tr;
      do @(posedge clock); while (!req_chan.ready);
      predict_tick(cl, cr, tl, tr);
      ticks_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (duty_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_gain(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_PROP_LEFT:  prop_gain[0] = data[GAIN_W-1:0];
         REG_PROP_RIGHT: prop_gain[1] = data[GAIN_W-1:0];
         REG_INTEG_LEFT: integ_gain[0] = data[GAIN_W-1:0];
         default:        integ_gain[1] = data[GAIN_W-1:0];
      endcase
      gain_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_gain(input csr_index_type idx);
      logic [CSR_DATA_W-1:0] want;
      want = CSR_DATA_W'(gain_of(idx));
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $error("%s: expected %0d, got %0d", idx.name(), want, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_gains();
      for (int i = 0; i < 4; i++) read_gain(csr_index_type'(i));
   endtask

   task automatic test_directed_ticks();
      send_word(32'd0, 32'd0, '0, '0);
      send_word(32'd100, -32'sd100, '0, '0);
      send_word(32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, '0, '0);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, 21'h0F_FFFF, 21'h10_0000);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, 21'h10_0000, 21'h0F_FFFF);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, '0, '0);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, '0, '0);
      for (int k = 1; k <= 3; k++)
         send_word(32'h8000_0000 + 40 * k, 32'h7FFF_FFFF - 40 * k,
                   TGT_W'(40 * SPEED_PER_COUNT), TGT_W'(-40 * SPEED_PER_COUNT));
      drain();
      enc_pos[0] = last_count[0];
      enc_pos[1] = last_count[1];
   endtask

   task automatic test_gain_extremes();
      logic [CSR_DATA_W-1:0] data;
      logic [GAIN_W-1:0]     level;
      for (int pass = 0; pass < 2; pass++) begin
         level = (pass == 0) ? '0 : GAIN_MAX;
         for (int i = 0; i < 4; i++) begin
            data = $urandom;
            data[GAIN_W-1:0] = level;
            write_gain(csr_index_type'(i), data);
            read_gain(csr_index_type'(i));
         end
         send_word(enc_pos[0] + 500, enc_pos[1] - 500, 21'h0F_FFFF, 21'h10_0000);
         send_word(enc_pos[0] + 500, enc_pos[1] - 500, 21'h10_0000, 21'h0F_FFFF);
         send_word(enc_pos[0] + 510, enc_pos[1] - 510, '0, '0);
         send_word(enc_pos[0] + 520, enc_pos[1] - 520, TGT_W'(3 * SPEED_PER_COUNT), '0);
         send_word(enc_pos[0] + 530, enc_pos[1] - 530, TGT_W'(2 * SPEED_PER_COUNT),
                   TGT_W'(-4 * SPEED_PER_COUNT));
         drain();
         enc_pos[0] = last_count[0];
         enc_pos[1] = last_count[1];
      end
   endtask

   task automatic cruise_word();
      logic [TGT_W-1:0] tgt [2];
      int jitter, noise;
      for (int w = 0; w < 2; w++) begin
         jitter = $urandom_range(0, 8);
         noise = $urandom_range(0, 40000);
         enc_pos[w] = enc_pos[w] + (cruise[w] + jitter - 4);
         tgt[w] = TGT_W'(cruise[w] * SPEED_PER_COUNT + noise - 20000);
      end
      send_word(enc_pos[0], enc_pos[1], tgt[0], tgt[1]);
   endtask

   task automatic test_random_ticks(input int phases, input int per_phase);
      logic [CSR_DATA_W-1:0] data;
      int r;
      for (int ph = 0; ph < phases; ph++) begin
         for (int i = 0; i < 4; i++) begin
            if (ph == 0 || $urandom_range(0, 2) == 0) begin
               data = $urandom;
               r = $urandom_range(0, 9);
               if (r == 0) data[GAIN_W-1:0] = '0;
               else if (r == 1) data[GAIN_W-1:0] = GAIN_MAX;
               else if (r < 4) data[GAIN_W-1:0] = $urandom;
               else data[GAIN_W-1:0] = $urandom_range(0, 70000);
               write_gain(csr_index_type'(i), data);
            end
         end
         steady_flow = ($urandom_range(0, 3) == 0);
         cruise[0] = $urandom_range(0, 300) - 150;
         cruise[1] = $urandom_range(0, 300) - 150;
         for (int k = 0; k < per_phase; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5) cruise[$urandom_range(0, 1)] = $urandom_range(0, 300) - 150;
            if (r < 80) begin
               cruise_word();
            end else if (r < 90) begin
               enc_pos[0] = $urandom;
               enc_pos[1] = $urandom;
               send_word(enc_pos[0], enc_pos[1], TGT_W'(cruise[0] * SPEED_PER_COUNT),
                         TGT_W'(cruise[1] * SPEED_PER_COUNT));
            end else begin
               enc_pos[0] = $urandom;
               enc_pos[1] = $urandom;
               send_word(enc_pos[0], enc_pos[1], TGT_W'($urandom), TGT_W'($urandom));
            end
         end
         drain();
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.count_left = '0;
      req_chan.count_right = '0;
      req_chan.target_speed_left = '0;
      req_chan.target_speed_right = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      prop_gain[0] = PROP_LEFT_RST;
      prop_gain[1] = PROP_RIGHT_RST;
      integ_gain[0] = INTEG_LEFT_RST;
      integ_gain[1] = INTEG_RIGHT_RST;
      for (int w = 0; w < 2; w++) begin
         last_count[w] = '0;
         speed_hist[w][0] = '0;
         speed_hist[w][1] = '0;
         integrator[w] = '0;
         enc_pos[w] = '0;
         cruise[w] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_gains();
      test_directed_ticks();
      test_gain_extremes();
      test_random_ticks(6, 80);

      repeat (60) @(posedge clock);
      $display("Covered %0d control ticks and %0d duty words over %0d gain writes.",
               ticks_sent, words_checked, gain_writes);
      $display("Clamped wheel updates predicted: %0d.", clamps_seen);
      if (errors == 0 && duty_expected.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("Timeout with %0d duty words outstanding.", duty_expected.size());
      $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/dwpi_pkg.sv
src/dwpi_req_if.sv
src/dwpi_rsp_if.sv
src/dwpi_wheel.sv
src/dual_wheel_pi_speed_loop_core.sv
tb/tb.sv
